/* src/rmp_pkg.sv */
// ----------------------------------------------------------------------------
// RESP message parser package
// Shared constants, codes and payload types of the RESP reply parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rmp_pkg;

    // Default limits
    localparam int MAX_BULK_LEN_DEF = 65536;
    localparam int MAX_ELEMENTS_DEF = 1024;

    // Stream characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;

    // Reply types
    localparam logic [2:0] TYPE_SIMPLE  = 3'd0;
    localparam logic [2:0] TYPE_ERROR   = 3'd1;
    localparam logic [2:0] TYPE_INTEGER = 3'd2;
    localparam logic [2:0] TYPE_BULK    = 3'd3;
    localparam logic [2:0] TYPE_ARRAY   = 3'd4;
    localparam logic [2:0] TYPE_UNKNOWN = 3'd5;

    // Error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_PREFIX    = 2'd1;
    localparam logic [1:0] ERR_TOO_LARGE = 2'd2;
    localparam logic [1:0] ERR_DIGIT     = 2'd3;

    typedef struct packed {
        logic [7:0] in_byte;
    } t_req;

    typedef struct packed {
        logic [2:0]         msg_type;
        logic [7:0]         data_byte;
        logic               payload_valid;
        logic signed [31:0] number;
        logic [9:0]         element_index;
        logic               element_done;
        logic               message_done;
        logic [1:0]         error_code;
    } t_rsp;

endpackage

`default_nettype wire

/* src/rmp_if.sv */
// ----------------------------------------------------------------------------
// RESP message parser stream interface
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmp_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/resp_message_parser.sv */
// ----------------------------------------------------------------------------
// RESP message parser
// Parses a RESP2 reply byte stream and emits payload, element and reply events.
// ----------------------------------------------------------------------------
//
//  Port     Dir  Payload  Meaning
//  i_req    in   t_req    one raw reply byte per request
//  o_rsp    out  t_rsp    one event per request that produces one
//
//  One byte per cycle barring stalls; each byte is parsed in the cycle it is taken
//  and its event, if any, appears in the output register on the next cycle.
//  i_req.ready is high whenever the output register is empty or being drained,
//  so an event held on a stalled o_rsp stops the input until it is taken.
//  Synchronous active-low reset returns the parser to idle, awaiting a type byte.
//
`default_nettype none

module resp_message_parser
    import rmp_pkg::*;
#(
    parameter int MAX_BULK_LEN = MAX_BULK_LEN_DEF,
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rmp_if.sink       i_req,
    rmp_if.source     o_rsp
);

    logic r_valid, n_valid;
    t_rsp r_rsp, n_rsp;
    logic take;
    logic hit;
    t_rsp core_rsp;

    assign i_req.ready = !r_valid || o_rsp.ready;
    assign take        = i_req.valid && i_req.ready;

    rmp_core #(
        .MAX_BULK_LEN (MAX_BULK_LEN),
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_req.data.in_byte),
        .o_hit   (hit),
        .o_rsp   (core_rsp)
    );

    always_comb begin
        n_valid = r_valid;
        n_rsp   = r_rsp;
        if (take && hit) begin
            n_valid = 1'b1;
            n_rsp   = core_rsp;
        end else if (o_rsp.ready) begin
            // drop the delivered event
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_rsp <= n_rsp;
    end

    assign o_rsp.valid = r_valid;
    assign o_rsp.data  = r_rsp;

`ifndef SYNTHESIS
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid |-> i_req.ready)
        else $error("input not ready with empty output register");

    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_rsp.payload_valid |->
            r_rsp.error_code == ERR_NONE && !r_rsp.message_done && !r_rsp.element_done)
        else $error("payload event carries end or error flags");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_rsp.error_code != ERR_NONE |->
            r_rsp.number == 32'sd0 && !r_rsp.message_done && !r_rsp.element_done)
        else $error("error event carries number or end flags");

    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_rsp.payload_valid |-> r_rsp.data_byte == 8'd0)
        else $error("data byte set outside payload");
`endif

endmodule

`default_nettype wire

/* src/rmp_core.sv */
// ----------------------------------------------------------------------------
// RESP message parser core
// Parse state and next-state logic; one byte per accepted request.
// ----------------------------------------------------------------------------
`default_nettype none

module rmp_core
    import rmp_pkg::*;
#(
    parameter int MAX_BULK_LEN = MAX_BULK_LEN_DEF,
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic [7:0] i_byte,
    output logic            o_hit,
    output t_rsp            o_rsp
);

    localparam int PLW = $clog2(MAX_BULK_LEN + 1);
    localparam int ELW = $clog2(MAX_ELEMENTS + 1);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_LINE,
        PH_LINE_LF,
        PH_INT,
        PH_INT_LF,
        PH_COUNT,
        PH_COUNT_LF,
        PH_BLEN,
        PH_BLEN_LF,
        PH_NULL_LF,
        PH_DATA,
        PH_DATA_CR,
        PH_DATA_LF,
        PH_PREFIX,
        PH_SKIP
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [2:0]         r_type, n_type;
    logic [31:0]        r_accum, n_accum;
    logic               r_minus, n_minus;
    logic [PLW-1:0]     r_left, n_left;
    logic [ELW-1:0]     r_elems, n_elems;
    logic [9:0]         r_idx, n_idx;

    logic               is_digit;
    logic               minus_ok;
    logic [31:0]        accum_step;
    logic               skip_or_idle_lf;

    assign is_digit        = (i_byte inside {[CH_0:CH_9]});
    assign minus_ok        = (i_byte == CH_MINUS) && !r_minus && (r_accum == 32'd0);
    assign accum_step      = (r_accum << 3) + (r_accum << 1) + {28'd0, i_byte[3:0]};
    assign skip_or_idle_lf = (i_byte == CH_LF);

    always_comb begin
        n_phase = r_phase;
        n_type  = r_type;
        n_accum = r_accum;
        n_minus = r_minus;
        n_left  = r_left;
        n_elems = r_elems;
        n_idx   = r_idx;
        o_hit   = 1'b0;
        o_rsp   = '0;

        case (r_phase)
            PH_IDLE: begin
                n_idx   = '0;
                n_elems = '0;
                n_left  = '0;
                n_accum = '0;
                n_minus = 1'b0;
                case (i_byte)
                    CH_PLUS: begin
                        n_type  = TYPE_SIMPLE;
                        n_accum = r_accum;
                        n_minus = r_minus;
                        n_phase = PH_LINE;
                    end
                    CH_MINUS: begin
                        n_type  = TYPE_ERROR;
                        n_accum = r_accum;
                        n_minus = r_minus;
                        n_phase = PH_LINE;
                    end
                    CH_COLON: begin
                        n_type  = TYPE_INTEGER;
                        n_phase = PH_INT;
                    end
                    CH_DOLLAR: begin
                        n_type  = TYPE_BULK;
                        n_phase = PH_BLEN;
                    end
                    CH_STAR: begin
                        n_type  = TYPE_ARRAY;
                        n_phase = PH_COUNT;
                    end
                    default: begin
                        n_type             = TYPE_UNKNOWN;
                        n_accum            = r_accum;
                        n_minus            = r_minus;
                        n_phase            = skip_or_idle_lf ? PH_IDLE : PH_SKIP;
                        o_hit              = 1'b1;
                        o_rsp.message_done = 1'b1;
                    end
                endcase
            end
            PH_LINE: begin
                if (i_byte == CH_CR) begin
                    n_phase = PH_LINE_LF;
                end else begin
                    o_hit               = 1'b1;
                    o_rsp.data_byte     = i_byte;
                    o_rsp.payload_valid = 1'b1;
                end
            end
            PH_LINE_LF: begin
                n_phase            = PH_IDLE;
                o_hit              = 1'b1;
                o_rsp.message_done = 1'b1;
            end
            PH_INT, PH_COUNT, PH_BLEN: begin
                if (i_byte == CH_CR) begin
                    if (r_phase == PH_INT) begin
                        n_phase = PH_INT_LF;
                    end else if (r_phase == PH_COUNT) begin
                        if (r_minus) begin
                            o_hit            = 1'b1;
                            o_rsp.error_code = ERR_DIGIT;
                        end else if (r_accum > 32'(MAX_ELEMENTS)) begin
                            o_hit            = 1'b1;
                            o_rsp.error_code = ERR_TOO_LARGE;
                        end else begin
                            n_phase = PH_COUNT_LF;
                        end
                    end else begin
                        if (r_minus) begin
                            if (r_accum != 32'd1) begin
                                o_hit            = 1'b1;
                                o_rsp.error_code = ERR_DIGIT;
                            end else begin
                                n_phase = PH_NULL_LF;
                            end
                        end else if (r_accum > 32'(MAX_BULK_LEN)) begin
                            o_hit            = 1'b1;
                            o_rsp.error_code = ERR_TOO_LARGE;
                        end else begin
                            n_left  = r_accum[PLW-1:0];
                            n_phase = PH_BLEN_LF;
                        end
                    end
                end else if (is_digit) begin
                    n_accum = accum_step;
                end else if (minus_ok) begin
                    n_minus = 1'b1;
                end else begin
                    o_hit            = 1'b1;
                    o_rsp.error_code = ERR_DIGIT;
                end
                // abandon the reply on any error raised above
                if (o_hit) begin
                    n_phase             = skip_or_idle_lf ? PH_IDLE : PH_SKIP;
                    o_rsp.element_index = r_idx;
                end
            end
            PH_INT_LF: begin
                n_phase            = PH_IDLE;
                o_hit              = 1'b1;
                o_rsp.number       = r_minus ? (32'd0 - r_accum) : r_accum;
                o_rsp.message_done = 1'b1;
            end
            PH_COUNT_LF: begin
                if (r_accum == 32'd0) begin
                    n_phase            = PH_IDLE;
                    o_hit              = 1'b1;
                    o_rsp.message_done = 1'b1;
                end else begin
                    n_elems = r_accum[ELW-1:0];
                    n_idx   = '0;
                    n_phase = PH_PREFIX;
                end
            end
            PH_PREFIX: begin
                if (i_byte == CH_DOLLAR) begin
                    n_accum = '0;
                    n_minus = 1'b0;
                    n_phase = PH_BLEN;
                end else begin
                    n_phase             = skip_or_idle_lf ? PH_IDLE : PH_SKIP;
                    o_hit               = 1'b1;
                    o_rsp.element_index = r_idx;
                    o_rsp.error_code    = ERR_PREFIX;
                end
            end
            PH_BLEN_LF: begin
                n_phase = (r_left == '0) ? PH_DATA_CR : PH_DATA;
            end
            PH_DATA: begin
                n_left = r_left - 1'b1;
                if (n_left == '0) begin
                    n_phase = PH_DATA_CR;
                end
                o_hit               = 1'b1;
                o_rsp.data_byte     = i_byte;
                o_rsp.payload_valid = 1'b1;
                o_rsp.element_index = (r_type == TYPE_ARRAY) ? r_idx : 10'd0;
            end
            PH_DATA_CR: begin
                n_phase = PH_DATA_LF;
            end
            PH_NULL_LF, PH_DATA_LF: begin
                o_hit              = 1'b1;
                o_rsp.element_done = 1'b1;
                o_rsp.number       = (r_phase == PH_NULL_LF) ? 32'hFFFF_FFFF : r_accum;
                o_rsp.message_done = 1'b1;
                if (r_type == TYPE_ARRAY) begin
                    o_rsp.element_index = r_idx;
                    n_elems             = r_elems - 1'b1;
                    n_idx               = r_idx + 10'd1;
                    o_rsp.message_done  = (n_elems == '0);
                end
                n_phase = o_rsp.message_done ? PH_IDLE : PH_PREFIX;
            end
            PH_SKIP: begin
                if (skip_or_idle_lf) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        o_rsp.msg_type = n_type;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_type  <= TYPE_SIMPLE;
            r_accum <= '0;
            r_minus <= 1'b0;
            r_left  <= '0;
            r_elems <= '0;
            r_idx   <= '0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_type  <= n_type;
            r_accum <= n_accum;
            r_minus <= n_minus;
            r_left  <= n_left;
            r_elems <= n_elems;
            r_idx   <= n_idx;
        end
    end

endmodule

`default_nettype wire

/* tb/resp_parse_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RESP parser checker
// Watches the byte and event channels of the RESP reply parser. It predicts
// the events of each accepted byte with its own parser state, and compares
// every accepted event, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------

module resp_parse_checker
    import rmp_pkg::*;
#(
    parameter int MAX_BULK_LEN = MAX_BULK_LEN_DEF,
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_req_ready,
    input  t_req i_req,
    input  logic i_rsp_valid,
    input  logic i_rsp_ready,
    input  t_rsp i_rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_results,
    output int   o_errors,
    output int   o_replies
);

    typedef enum logic [3:0] {
        ST_WAIT_TYPE,
        ST_LINE,
        ST_LINE_END,
        ST_INT,
        ST_INT_END,
        ST_COUNT,
        ST_COUNT_END,
        ST_LEN,
        ST_LEN_END,
        ST_NULL_END,
        ST_DATA,
        ST_TRAIL_CR,
        ST_TRAIL_LF,
        ST_ELEM_PREFIX,
        ST_SKIP_LINE
    } t_parse_state;

    t_parse_state state;
    logic [2:0]   reply_type;
    logic [31:0]  num_acc;
    logic         num_neg;
    logic [16:0]  bytes_left;
    logic [10:0]  elems_left;
    logic [9:0]   elem_idx;

    t_rsp pending_events[$];
    int   fail_count    = 0;
    int   results_seen  = 0;
    int   error_results = 0;
    int   replies_done  = 0;
    int   pending_n     = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_n;
    assign o_results    = results_seen;
    assign o_errors     = error_results;
    assign o_replies    = replies_done;

    task automatic clear_state();
        state      = ST_WAIT_TYPE;
        reply_type = '0;
        num_acc    = '0;
        num_neg    = 1'b0;
        bytes_left = '0;
        elems_left = '0;
        elem_idx   = '0;
        pending_events.delete();
    endtask

    task automatic emit(input logic [7:0] data, input logic pv, input logic [31:0] num,
                        input logic [9:0] idx, input logic ed, input logic md,
                        input logic [1:0] err);
        t_rsp r;
        r.msg_type      = reply_type;
        r.data_byte     = data;
        r.payload_valid = pv;
        r.number        = num;
        r.element_index = idx;
        r.element_done  = ed;
        r.message_done  = md;
        r.error_code    = err;
        pending_events.insert(pending_events.size(), r);
    endtask

    // abandon the reply; an offending line feed ends the line at once
    task automatic flag_error(input logic [1:0] code, input logic [7:0] b);
        state = (b == CH_LF) ? ST_WAIT_TYPE : ST_SKIP_LINE;
        emit(8'h00, 1'b0, 32'd0, elem_idx, 1'b0, 1'b0, code);
    endtask

    task automatic begin_number(input t_parse_state next);
        num_acc = '0;
        num_neg = 1'b0;
        state   = next;
    endtask

    function automatic bit take_number_char(input logic [7:0] b);
        if (b >= CH_0 && b <= CH_9) begin
            num_acc = num_acc * 32'd10 + 32'(b - CH_0);
            return 1'b1;
        end
        if (b == CH_MINUS && !num_neg && num_acc == '0) begin
            num_neg = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic close_element(input logic [31:0] num);
        logic [9:0] idx;
        logic       done;
        idx  = '0;
        done = 1'b1;
        if (reply_type == TYPE_ARRAY) begin
            idx        = elem_idx;
            elems_left = elems_left - 11'd1;
            elem_idx   = elem_idx + 10'd1;
            done       = (elems_left == '0);
        end
        state = done ? ST_WAIT_TYPE : ST_ELEM_PREFIX;
        emit(8'h00, 1'b0, num, idx, 1'b1, done, ERR_NONE);
    endtask

    task automatic parse_byte(input logic [7:0] b);
        case (state)
            ST_WAIT_TYPE: begin
                elem_idx   = '0;
                elems_left = '0;
                bytes_left = '0;
                case (b)
                    CH_PLUS: begin
                        reply_type = TYPE_SIMPLE;
                        state      = ST_LINE;
                    end
                    CH_MINUS: begin
                        reply_type = TYPE_ERROR;
                        state      = ST_LINE;
                    end
                    CH_COLON: begin
                        reply_type = TYPE_INTEGER;
                        begin_number(ST_INT);
                    end
                    CH_DOLLAR: begin
                        reply_type = TYPE_BULK;
                        begin_number(ST_LEN);
                    end
                    CH_STAR: begin
                        reply_type = TYPE_ARRAY;
                        begin_number(ST_COUNT);
                    end
                    default: begin
                        reply_type = TYPE_UNKNOWN;
                        state      = (b == CH_LF) ? ST_WAIT_TYPE : ST_SKIP_LINE;
                        emit(8'h00, 1'b0, 32'd0, 10'd0, 1'b0, 1'b1, ERR_NONE);
                    end
                endcase
            end
            ST_LINE: begin
                if (b == CH_CR) state = ST_LINE_END;
                else emit(b, 1'b1, 32'd0, 10'd0, 1'b0, 1'b0, ERR_NONE);
            end
            ST_LINE_END: begin
                state = ST_WAIT_TYPE;
                emit(8'h00, 1'b0, 32'd0, 10'd0, 1'b0, 1'b1, ERR_NONE);
            end
            ST_INT: begin
                if (b == CH_CR) state = ST_INT_END;
                else if (!take_number_char(b)) flag_error(ERR_DIGIT, b);
            end
            ST_INT_END: begin
                state = ST_WAIT_TYPE;
                emit(8'h00, 1'b0, num_neg ? 32'd0 - num_acc : num_acc, 10'd0, 1'b0, 1'b1,
                     ERR_NONE);
            end
            ST_COUNT: begin
                if (b == CH_CR) begin
                    if (num_neg) flag_error(ERR_DIGIT, b);
                    else if (num_acc > 32'(MAX_ELEMENTS)) flag_error(ERR_TOO_LARGE, b);
                    else state = ST_COUNT_END;
                end else if (!take_number_char(b)) begin
                    flag_error(ERR_DIGIT, b);
                end
            end
            ST_COUNT_END: begin
                if (num_acc == '0) begin
                    state = ST_WAIT_TYPE;
                    emit(8'h00, 1'b0, 32'd0, 10'd0, 1'b0, 1'b1, ERR_NONE);
                end else begin
                    elems_left = num_acc[10:0];
                    elem_idx   = '0;
                    state      = ST_ELEM_PREFIX;
                end
            end
            ST_ELEM_PREFIX: begin
                if (b == CH_DOLLAR) begin_number(ST_LEN);
                else flag_error(ERR_PREFIX, b);
            end
            ST_LEN: begin
                if (b == CH_CR) begin
                    if (num_neg) begin
                        // only minus one stands for a null string
                        if (num_acc != 32'd1) flag_error(ERR_DIGIT, b);
                        else state = ST_NULL_END;
                    end else if (num_acc > 32'(MAX_BULK_LEN)) begin
                        flag_error(ERR_TOO_LARGE, b);
                    end else begin
                        bytes_left = num_acc[16:0];
                        state      = ST_LEN_END;
                    end
                end else if (!take_number_char(b)) begin
                    flag_error(ERR_DIGIT, b);
                end
            end
            ST_LEN_END: state = (bytes_left == '0) ? ST_TRAIL_CR : ST_DATA;
            ST_NULL_END: close_element(32'hFFFF_FFFF);
            ST_DATA: begin
                bytes_left = bytes_left - 17'd1;
                if (bytes_left == '0) state = ST_TRAIL_CR;
                emit(b, 1'b1, 32'd0, (reply_type == TYPE_ARRAY) ? elem_idx : 10'd0,
                     1'b0, 1'b0, ERR_NONE);
            end
            ST_TRAIL_CR: state = ST_TRAIL_LF;
            ST_TRAIL_LF: close_element(num_acc);
            ST_SKIP_LINE: begin
                if (b == CH_LF) state = ST_WAIT_TYPE;
            end
            default: state = ST_WAIT_TYPE;
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("[%0t] event %0d: %s", $time, results_seen, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    endtask

    task automatic check_event(input t_rsp got);
        t_rsp want;
        results_seen++;
        if (got.error_code != ERR_NONE) error_results++;
        if (got.message_done) replies_done++;
        if (pending_events.size() == 0) begin
            report_mismatch($sformatf("unexpected event, type %0d number %0d error %0d",
                                      got.msg_type, got.number, got.error_code));
            return;
        end
        want = pending_events.pop_front();
        compare_field("msg_type", 32'(got.msg_type), 32'(want.msg_type));
        compare_field("data_byte", 32'(got.data_byte), 32'(want.data_byte));
        compare_field("payload_valid", 32'(got.payload_valid), 32'(want.payload_valid));
        compare_field("number", got.number, want.number);
        compare_field("element_index", 32'(got.element_index), 32'(want.element_index));
        compare_field("element_done", 32'(got.element_done), 32'(want.element_done));
        compare_field("message_done", 32'(got.message_done), 32'(want.message_done));
        compare_field("error_code", 32'(got.error_code), 32'(want.error_code));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
        end else begin
            if (i_rsp_valid && i_rsp_ready) check_event(i_rsp);
            if (i_req_valid && i_req_ready) parse_byte(i_req.in_byte);
        end
        pending_n <= pending_events.size();
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RESP parser testbench
// Feeds the parser directed replies, then random well-formed, broken and
// garbage replies under several idle and stall profiles, a long output
// hold-off and one long array under the largest legal count. The checker
// predicts and compares.
// ----------------------------------------------------------------------------

module testbench;
    import rmp_pkg::*;

    localparam int PHASE_BYTES = 360;
    localparam int HOLD_CYCLES = 300;
    localparam int ARRAY_ELEMS = 30;

    logic clk = 1'b0;
    logic rst_n;

    rmp_if #(.T(t_req)) req_ch ();
    rmp_if #(.T(t_rsp)) rsp_ch ();

    int fail_count, pending, results_seen, error_results, replies_done;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int sent_bytes     = 0;
    int drain_cycles   = 0;
    bit hold_go        = 1'b0;
    int idle_profile[4][2] = '{'{0, 0}, '{57, 0}, '{0, 57}, '{23, 23}};

    logic [7:0] byte_q[$];

    resp_message_parser dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    resp_parse_checker chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_ch.valid),
        .i_req_ready (req_ch.ready),
        .i_req       (req_ch.data),
        .i_rsp_valid (rsp_ch.valid),
        .i_rsp_ready (rsp_ch.ready),
        .i_rsp       (rsp_ch.data),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_results   (results_seen),
        .o_errors    (error_results),
        .o_replies   (replies_done)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial begin
        #3_000_000;
        $display("FAIL resp_message_parser");
        $finish;
    end

    // output side: random stalls, or a counted hold-off when asked
    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_go) begin
                hold_go   = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic add_byte(input logic [7:0] b);
        byte_q.insert(byte_q.size(), b);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    task automatic put_line(input string s);
        put_text(s);
        add_byte(CH_CR);
        add_byte(CH_LF);
    endtask

    // any byte after a carriage return ends the line
    task automatic put_eol();
        add_byte(CH_CR);
        add_byte(($urandom_range(7) == 0) ? 8'($urandom_range(255)) : CH_LF);
    endtask

    task automatic put_digits(input int n);
        repeat (n) add_byte(CH_0 + 8'($urandom_range(9)));
    endtask

    function automatic logic [7:0] line_char();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        return (b == CH_CR) ? 8'h20 : b;
    endfunction

    function automatic logic [7:0] non_number_char();
        logic [7:0] b;
        do b = 8'($urandom_range(255));
        while ((b >= CH_0 && b <= CH_9) || b == CH_MINUS || b == CH_CR);
        return b;
    endfunction

    task automatic add_bulk();
        int k, len;
        k = $urandom_range(99);
        add_byte(CH_DOLLAR);
        if (k < 12) begin
            put_line("-1");
        end else begin
            if (k < 17) begin
                len = 0;
                put_line("");
            end else begin
                len = (k < 88) ? $urandom_range(6) : $urandom_range(40, 7);
                put_text($sformatf("%0d", len));
                put_eol();
            end
            repeat (len) add_byte(8'($urandom_range(255)));
            if ($urandom_range(9) == 0) begin
                add_byte(8'($urandom_range(255)));
                add_byte(8'($urandom_range(255)));
            end else begin
                add_byte(CH_CR);
                add_byte(CH_LF);
            end
        end
    endtask

    task automatic add_broken();
        int n;
        logic [7:0] b;
        case ($urandom_range(7))
            0: begin
                add_byte(CH_COLON);
                put_digits($urandom_range(3));
                add_byte(8'h61 + 8'($urandom_range(25)));
                put_line("");
            end
            1: begin
                add_byte(CH_COLON);
                put_digits($urandom_range(3, 1));
                add_byte(CH_MINUS);
                put_digits($urandom_range(2));
                put_line("");
            end
            2: begin
                n = $urandom_range(99);
                put_line($sformatf("$-%0d", (n == 1) ? 0 : n));
            end
            3: put_line($sformatf("$%0d", $urandom_range(4000000, 65537)));
            4: put_line($sformatf("*%0d", $urandom_range(99999, 1025)));
            5: put_line($sformatf("*-%0d", $urandom_range(9)));
            6: begin
                n = $urandom_range(3, 1);
                put_line($sformatf("*%0d", n));
                if (n > 1 && $urandom_range(1)) add_bulk();
                do b = 8'($urandom_range(255));
                while (b == CH_DOLLAR);
                add_byte(b);
                put_line("");
            end
            default: begin
                add_byte($urandom_range(1) ? CH_DOLLAR : CH_STAR);
                put_digits($urandom_range(3));
                add_byte(non_number_char());
                put_line("");
            end
        endcase
    endtask

    task automatic add_reply();
        int kind, n;
        logic [7:0] b;
        kind = $urandom_range(99);
        if (kind < 12) begin
            add_byte($urandom_range(1) ? CH_PLUS : CH_MINUS);
            repeat ($urandom_range(8)) add_byte(line_char());
            put_eol();
        end else if (kind < 24) begin
            add_byte(CH_COLON);
            if ($urandom_range(3) == 0) add_byte(CH_MINUS);
            put_digits(($urandom_range(7) == 0) ? $urandom_range(12, 10) : $urandom_range(5));
            put_eol();
        end else if (kind < 44) begin
            add_bulk();
        end else if (kind < 70) begin
            n = ($urandom_range(9) == 0) ? 0 : $urandom_range(5, 1);
            put_text($sformatf("*%0d", n));
            put_eol();
            repeat (n) add_bulk();
        end else if (kind < 86) begin
            add_broken();
        end else begin
            // garbage type byte, then skip to the line feed
            do b = 8'($urandom_range(255));
            while (b == CH_PLUS || b == CH_MINUS || b == CH_COLON || b == CH_DOLLAR ||
                   b == CH_STAR);
            add_byte(b);
            if (b != CH_LF) begin
                repeat ($urandom_range(3)) add_byte(8'($urandom_range(9, 0)) + 8'h11);
                add_byte(CH_LF);
            end
        end
    endtask

    task automatic add_directed();
        put_line("+OK");
        put_line("-ERR");
        put_line(":-2147483648");
        put_line(":4294967295");
        put_line(":99999999999");
        put_line(":-");
        put_line("$3");
        put_line("abc");
        put_line("$-1");
        put_line("*0");
        put_line("*3");
        put_line("$1");
        put_line("x");
        put_line("$-1");
        put_line("$0");
        put_line("");
        put_line("$65537");
        put_line("*1025");
        put_line("*-1");
        put_line("$-2");
        put_line(":1-2");
        put_line("*1");
        put_line("+x");
        put_text("?x");
        add_byte(CH_LF);
        add_byte(CH_LF);
        put_text("+a");
        add_byte(CH_CR);
        add_byte(8'hFF);
        put_line("$2");
        add_byte(8'h00);
        add_byte(8'hFF);
        put_line("");
        put_line("$");
        put_line("");
    endtask

    task automatic send_stream();
        logic [7:0] b;
        while (byte_q.size() != 0) begin
            b = byte_q.pop_front();
            while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
                req_ch.valid <= 1'b0;
                @(posedge clk);
            end
            req_ch.valid        <= 1'b1;
            req_ch.data.in_byte <= b;
            @(posedge clk);
            while (!req_ch.ready) @(posedge clk);
            sent_bytes++;
        end
    endtask

    initial begin
        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        add_directed();
        send_stream();

        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = idle_profile[p][0];
            recv_stall_pct = idle_profile[p][1];
            while (byte_q.size() < PHASE_BYTES) add_reply();
            send_stream();
        end

        // hold the output so the parser backs up into the input
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_go        = 1'b1;
        while (byte_q.size() < 120) add_reply();
        send_stream();

        // largest legal count, nulls mixed with one-byte strings, cut short
        // by a bad element prefix
        recv_stall_pct = 23;
        put_line("*1024");
        repeat (ARRAY_ELEMS) begin
            if ($urandom_range(3) == 0) begin
                put_line("$1");
                add_byte(8'($urandom_range(255)));
                put_line("");
            end else begin
                put_line("$-1");
            end
        end
        add_byte(CH_PLUS);
        put_line("");
        send_stream();

        req_ch.valid <= 1'b0;
        recv_stall_pct = 0;
        do begin
            @(posedge clk);
            drain_cycles++;
        end while (pending != 0 && drain_cycles < 20000);
        repeat (8) @(posedge clk);

        $display("Sent %0d reply bytes under four idle profiles, an output hold-off",
                 sent_bytes);
        $display("and a long array under the top count; %0d events, %0d replies, %0d errors.",
                 results_seen, replies_done, error_results);
        if (pending != 0) $display("%0d predicted events never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS resp_message_parser");
        end else begin
            $display("FAIL resp_message_parser");
        end
        $finish;
    end

endmodule

/* resp_message_parser.f */
src/rmp_pkg.sv
src/rmp_if.sv
src/rmp_core.sv
src/resp_message_parser.sv
tb/resp_parse_checker.sv
tb/testbench.sv
